[hdl/mra_pkg.sv]
package mra_pkg;

  // register file geometry, fixed by the 5-bit register fields
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 5;
  localparam int NUM_REGS  = 32;

  // default depth of the queue between decode and execute
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] SIGN_MASK = 32'h8000_0000;

  // action codes of the command channel
  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // function codes of the R-type word
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRAV = 6'h07;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;

  // opcode of all R-type words
  localparam logic [5:0] OPC_RTYPE = 6'h00;

  // internal operation codes after decode
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd0;
  localparam logic [OP_W-1:0] OP_SLL  = 4'd1;
  localparam logic [OP_W-1:0] OP_SRAV = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd3;
  localparam logic [OP_W-1:0] OP_ADDU = 4'd4;
  localparam logic [OP_W-1:0] OP_AND  = 4'd5;
  localparam logic [OP_W-1:0] OP_OR   = 4'd6;
  localparam logic [OP_W-1:0] OP_XOR  = 4'd7;
  localparam logic [OP_W-1:0] OP_BAD  = 4'd8;

  // one decoded transaction as it sits in the queue
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [REG_IDX_W-1:0] dest;
    logic [REG_IDX_W-1:0] rs;
    logic [REG_IDX_W-1:0] rt;
    logic [REG_IDX_W-1:0] shamt;
    logic [DATA_W-1:0]    load_value;
  } entry_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/mra_ram.sv]
module mra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port, read returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/mra_front.sv]
module mra_front import mra_pkg::*; (
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic                 action,
  input  logic [DATA_W-1:0]    instruction,
  input  logic [REG_IDX_W-1:0] load_index,
  input  logic [DATA_W-1:0]    load_value,
  input  q_stat_t              q_stat,
  output logic                 push,
  output entry_t               push_entry
);

  logic [5:0] opc;
  logic [5:0] fn;

  assign opc = instruction[31:26];
  assign fn  = instruction[5:0];

  // take a transaction whenever the queue has room
  assign cmd_ready = !q_stat.full;
  assign push      = cmd_valid && !q_stat.full;

  // classify the transaction into an internal operation
  always_comb begin
    push_entry.rs         = instruction[25:21];
    push_entry.rt         = instruction[20:16];
    push_entry.shamt      = instruction[10:6];
    push_entry.load_value = load_value;
    push_entry.dest       = instruction[15:11];
    push_entry.op         = OP_BAD;
    if (action == ACT_LOAD) begin
      push_entry.dest = load_index;
      push_entry.op   = OP_LOAD;
    end else if (opc == OPC_RTYPE) begin
      case (fn)
        FN_SLL:  push_entry.op = OP_SLL;
        FN_SRAV: push_entry.op = OP_SRAV;
        FN_ADD:  push_entry.op = OP_ADD;
        FN_ADDU: push_entry.op = OP_ADDU;
        FN_AND:  push_entry.op = OP_AND;
        FN_OR:   push_entry.op = OP_OR;
        FN_XOR:  push_entry.op = OP_XOR;
        default: push_entry.op = OP_BAD;
      endcase
    end
  end

endmodule

[hdl/mra_queue.sv]
module mra_queue import mra_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t q_stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/mra_back.sv]
module mra_back import mra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  entry_t               head,
  input  q_stat_t              q_stat,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [REG_IDX_W-1:0] dest_index,
  output logic [DATA_W-1:0]    result_value,
  output logic                 wrote,
  output logic                 overflow,
  output logic                 unsupported
);

  // execute stage
  entry_t               ex;
  logic                 ex_valid;
  logic                 ex_fire;

  // write that landed in the cycle the execute item read the file
  logic                 fwd_en;
  logic [REG_IDX_W-1:0] fwd_idx;
  logic [DATA_W-1:0]    fwd_val;

  logic [NUM_REGS-1:0]  reg_valid;
  logic [DATA_W-1:0]    ram_a;
  logic [DATA_W-1:0]    ram_b;
  logic [DATA_W-1:0]    opa;
  logic [DATA_W-1:0]    opb;
  logic [DATA_W-1:0]    sum;
  logic [DATA_W-1:0]    value;
  logic                 ovf;
  logic                 unsup;
  logic                 wr_req;
  logic                 wr_en;

  assign ex_fire = ex_valid && (!res_valid || res_ready);
  assign pop     = !q_stat.empty && (!ex_valid || ex_fire);
  assign wr_en   = ex_fire && wr_req;

  // register file, one copy per read port
  mra_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ex.dest),
    .wdata (value),
    .re    (pop),
    .raddr (head.rs),
    .rdata (ram_a)
  );

  mra_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ex.dest),
    .wdata (value),
    .re    (pop),
    .raddr (head.rt),
    .rdata (ram_b)
  );

  // valid bits stand in for the all-zero reset of the file
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (wr_en) begin
      reg_valid[ex.dest] <= 1'b1;
    end
  end

  // issue from the queue into the execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      fwd_en   <= 1'b0;
    end else if (pop) begin
      ex_valid <= 1'b1;
      fwd_en   <= wr_en;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ex      <= head;
      fwd_idx <= ex.dest;
      fwd_val <= value;
    end
  end

  // operand select: bypass, stored value, or reset zero
  always_comb begin
    if (fwd_en && fwd_idx == ex.rs) begin
      opa = fwd_val;
    end else if (reg_valid[ex.rs]) begin
      opa = ram_a;
    end else begin
      opa = '0;
    end
    if (fwd_en && fwd_idx == ex.rt) begin
      opb = fwd_val;
    end else if (reg_valid[ex.rt]) begin
      opb = ram_b;
    end else begin
      opb = '0;
    end
  end

  assign sum = opa + opb;

  // alu
  always_comb begin
    value = '0;
    ovf   = 1'b0;
    unsup = 1'b0;
    case (ex.op)
      OP_LOAD: value = ex.load_value;
      OP_SLL:  value = opb << ex.shamt;
      OP_SRAV: value = DATA_W'($signed(opb) >>> opa[REG_IDX_W-1:0]);
      OP_ADD: begin
        value = sum;
        ovf   = |(((opa ^ sum) & (opb ^ sum)) & SIGN_MASK);
      end
      OP_ADDU: value = sum;
      OP_AND:  value = opa & opb;
      OP_OR:   value = opa | opb;
      OP_XOR:  value = opa ^ opb;
      default: unsup = 1'b1;
    endcase
    wr_req = !unsup && !ovf && (ex.dest != '0);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ex_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      dest_index   <= ex.dest;
      result_value <= value;
      wrote        <= wr_req;
      overflow     <= ovf;
      unsupported  <= unsup;
    end
  end

endmodule

[hdl/mips_r_type_alu_execute_top.sv]
// MIPS R-type execute block with a 32 x 32-bit register file.
// Command channel (cmd_valid/cmd_ready) carries either a direct register
// load (action = 1) or an R-type instruction word (action = 0).
// Result channel (res_valid/res_ready) returns one transaction per command:
// target register, value, write flag, signed-add overflow and unsupported.
// A decode front classifies each command into a short queue; the execute
// back reads the file, runs the alu and writes back, bypassing the write
// of the previous instruction so dependent instructions run back to back.
// Throughput: one transaction per cycle while res_ready holds high. A command
// goes from the queue via the registered file read to the result register.
// Reset (rst, synchronous) empties the queue and pipeline and clears the
// file to zero through per-register valid bits, with no clearing pass.
// When the receiver stalls, the result register holds, the execute stage
// and queue fill, and cmd_ready falls once the queue is full.
module mips_r_type_alu_execute_top import mra_pkg::*; #(
  parameter int Q_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic                 action,
  input  logic [DATA_W-1:0]    instruction,
  input  logic [REG_IDX_W-1:0] load_index,
  input  logic [DATA_W-1:0]    load_value,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [REG_IDX_W-1:0] dest_index,
  output logic [DATA_W-1:0]    result_value,
  output logic                 wrote,
  output logic                 overflow,
  output logic                 unsupported
);

  q_stat_t q_stat;
  entry_t  push_entry;
  entry_t  head;
  logic    push;
  logic    pop;

  mra_front u_front (
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .action      (action),
    .instruction (instruction),
    .load_index  (load_index),
    .load_value  (load_value),
    .q_stat      (q_stat),
    .push        (push),
    .push_entry  (push_entry)
  );

  mra_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  mra_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .dest_index   (dest_index),
    .result_value (result_value),
    .wrote        (wrote),
    .overflow     (overflow),
    .unsupported  (unsupported)
  );

  // an accepted command is in the queue at the next edge
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !q_stat.empty)
    else $error("accepted command missing from queue");

  // the back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // an overflowing add never writes back
  a_ovf_no_write: assert property (@(posedge clk) disable iff (rst)
    (res_valid && overflow) |-> (!wrote && !unsupported))
    else $error("overflow result marked as written");

  // unsupported results are zero and never write back
  a_unsup_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && unsupported) |-> (!wrote && result_value == '0))
    else $error("unsupported result not cleared");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mra_pkg::*;

  // codes the block does not handle
  localparam logic [5:0] FN_UNKNOWN = 6'h3f;
  localparam logic [5:0] OPC_BAD    = 6'h3f;

  localparam int RAND_ITEMS  = 1880;
  localparam int CALM_ITEMS  = 250;
  localparam int HOLD_CYCLES = 60;

  // one result transaction
  typedef struct packed {
    logic [REG_IDX_W-1:0] dest;
    logic [DATA_W-1:0]    value;
    logic                 wrote;
    logic                 ovf;
    logic                 unsup;
  } result_t;

  // one directed stimulus row, with an optional typed-in result
  typedef struct packed {
    logic                 act;
    logic [DATA_W-1:0]    word;
    logic [REG_IDX_W-1:0] li;
    logic [DATA_W-1:0]    lv;
    logic                 typed;
    result_t              exp;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  logic                 action = ACT_EXEC;
  logic [DATA_W-1:0]    instruction = '0;
  logic [REG_IDX_W-1:0] load_index = '0;
  logic [DATA_W-1:0]    load_value = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  logic [REG_IDX_W-1:0] dest_index;
  logic [DATA_W-1:0]    result_value;
  logic                 wrote;
  logic                 overflow;
  logic                 unsupported;

  logic [DATA_W-1:0] gpr_shadow [NUM_REGS];
  result_t           pending_results [$];
  row_t              dir_rows [$];
  int                err_cnt = 0;
  bit                snd_idle = 1'b1;
  bit                rcv_idle = 1'b1;
  bit                hold_req = 1'b0;

  mips_r_type_alu_execute_top dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .action       (action),
    .instruction  (instruction),
    .load_index   (load_index),
    .load_value   (load_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .dest_index   (dest_index),
    .result_value (result_value),
    .wrote        (wrote),
    .overflow     (overflow),
    .unsupported  (unsupported)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] rtype(input logic [5:0] opc,
      input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] rd,
      input logic [4:0] sh, input logic [5:0] fn);
    return {opc, rs, rt, rd, sh, fn};
  endfunction

  // execute one command against the shadow register file
  function automatic result_t run_r_type(input logic act, input logic [DATA_W-1:0] word,
      input logic [REG_IDX_W-1:0] li, input logic [DATA_W-1:0] lv);
    result_t r;
    logic [DATA_W-1:0] a, b;
    logic [4:0] rs, rt, rd, sh;
    r = '0;
    if (act == ACT_LOAD) begin
      r.dest  = li;
      r.value = lv;
      if (li != 0) begin
        gpr_shadow[li] = lv;
        r.wrote = 1'b1;
      end
      return r;
    end
    rs = word[25:21];
    rt = word[20:16];
    rd = word[15:11];
    sh = word[10:6];
    a  = gpr_shadow[rs];
    b  = gpr_shadow[rt];
    r.dest = rd;
    if (word[31:26] != OPC_RTYPE) begin
      r.unsup = 1'b1;
    end else begin
      case (word[5:0])
        FN_SLL:  r.value = b << sh;
        FN_SRAV: r.value = $signed(b) >>> a[4:0];
        FN_ADD: begin
          r.value = a + b;
          r.ovf   = (a[31] == b[31]) && (r.value[31] != a[31]);
        end
        FN_ADDU: r.value = a + b;
        FN_AND:  r.value = a & b;
        FN_OR:   r.value = a | b;
        FN_XOR:  r.value = a ^ b;
        default: r.unsup = 1'b1;
      endcase
    end
    if (r.unsup) begin
      r.value = '0;
    end else if (!r.ovf && rd != 0) begin
      gpr_shadow[rd] = r.value;
      r.wrote = 1'b1;
    end
    return r;
  endfunction

  // offer one transaction, wait for its acceptance, record what should come back
  task automatic issue_cmd(input logic act, input logic [DATA_W-1:0] word,
      input logic [REG_IDX_W-1:0] li, input logic [DATA_W-1:0] lv,
      input logic typed, input result_t exp);
    result_t r;
    if (snd_idle && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    action      <= act;
    instruction <= word;
    load_index  <= li;
    load_value  <= lv;
    cmd_valid   <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    r = run_r_type(act, word, li, lv);
    pending_results.push_back(typed ? exp : r);
    @(negedge clk);
  endtask

  // stop offering and wait until every expected result has come
  task automatic drain_results;
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [4:0] pick_reg;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 5'd0;
    if (k <= 5) return 5'($urandom_range(1, 4));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value;
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_fn;
    case ($urandom_range(0, 6))
      0:       return FN_SLL;
      1:       return FN_SRAV;
      2:       return FN_ADD;
      3:       return FN_ADDU;
      4:       return FN_AND;
      5:       return FN_OR;
      default: return FN_XOR;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
      input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none expected: dest_index 0x%0h", dest_index);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        compare_field("dest_index", 32'(e.dest), 32'(dest_index));
        compare_field("result_value", e.value, result_value);
        compare_field("wrote", 32'(e.wrote), 32'(wrote));
        compare_field("overflow", 32'(e.ovf), 32'(overflow));
        compare_field("unsupported", 32'(e.unsup), 32'(unsupported));
      end
    end
  end

  // receiver: random stalls, and a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (rcv_idle && $urandom_range(0, 7) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // stimulus
  initial begin
    logic                 act;
    logic [DATA_W-1:0]    word;
    logic [REG_IDX_W-1:0] li;
    logic [DATA_W-1:0]    lv;
    int                   k;

    for (int i = 0; i < NUM_REGS; i++) gpr_shadow[i] = '0;

    dir_rows = '{
      // read right after reset: everything is zero
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD), 5'd0, 32'h0,
        1'b1, '{5'd3, 32'h0000_0000, 1'b1, 1'b0, 1'b0}},
      '{ACT_LOAD, 32'h0, 5'd1, 32'h7fff_ffff, 1'b1, '{5'd1, 32'h7fff_ffff, 1'b1, 1'b0, 1'b0}},
      '{ACT_LOAD, 32'h0, 5'd2, 32'h0000_0001, 1'b1, '{5'd2, 32'h0000_0001, 1'b1, 1'b0, 1'b0}},
      // load to register zero is dropped
      '{ACT_LOAD, 32'hffff_ffff, 5'd0, 32'hffff_ffff,
        1'b1, '{5'd0, 32'hffff_ffff, 1'b0, 1'b0, 1'b0}},
      // positive signed overflow
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD), 5'd0, 32'h0,
        1'b1, '{5'd3, 32'h8000_0000, 1'b0, 1'b1, 1'b0}},
      '{ACT_LOAD, 32'h0, 5'd4, 32'h8000_0000, 1'b1, '{5'd4, 32'h8000_0000, 1'b1, 1'b0, 1'b0}},
      '{ACT_LOAD, 32'hdead_beef, 5'd5, 32'hffff_ffff,
        1'b1, '{5'd5, 32'hffff_ffff, 1'b1, 1'b0, 1'b0}},
      // negative signed overflow
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd4, 5'd5, 5'd6, 5'd0, FN_ADD), 5'd0, 32'h0,
        1'b1, '{5'd6, 32'h7fff_ffff, 1'b0, 1'b1, 1'b0}},
      // unsigned add of the same operands raises no flag
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd1, 5'd2, 5'd7, 5'd0, FN_ADDU), 5'd0, 32'h0,
        1'b1, '{5'd7, 32'h8000_0000, 1'b1, 1'b0, 1'b0}},
      // shamt and load fields carry junk, must be ignored
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd5, 5'd2, 5'd8, 5'd31, FN_ADD), 5'd31, 32'hffff_ffff,
        1'b0, '0},
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd5, 5'd1, 5'd9, 5'd0, FN_AND), 5'd0, 32'h0, 1'b0, '0},
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd4, 5'd2, 5'd10, 5'd0, FN_OR), 5'd0, 32'h0, 1'b0, '0},
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd5, 5'd1, 5'd11, 5'd0, FN_XOR), 5'd0, 32'h0, 1'b0, '0},
      // sll with the largest and smallest shift, rs ignored
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd7, 5'd5, 5'd12, 5'd31, FN_SLL), 5'd0, 32'h0, 1'b0, '0},
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd0, 5'd1, 5'd13, 5'd0, FN_SLL), 5'd0, 32'h0, 1'b0, '0},
      // srav sign fill, amount from low bits of rs
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd5, 5'd4, 5'd14, 5'd0, FN_SRAV), 5'd0, 32'h0, 1'b0, '0},
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd2, 5'd1, 5'd15, 5'd0, FN_SRAV), 5'd0, 32'h0, 1'b0, '0},
      // unknown function code and non R-type opcode
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd1, 5'd2, 5'd16, 5'd0, FN_UNKNOWN), 5'd0, 32'h0,
        1'b1, '{5'd16, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      '{ACT_EXEC, rtype(OPC_BAD, 5'd1, 5'd2, 5'd17, 5'd0, FN_ADD), 5'd0, 32'h0,
        1'b1, '{5'd17, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      // result to register zero shows the value but does not write
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd1, 5'd2, 5'd0, 5'd0, FN_ADDU), 5'd0, 32'h0,
        1'b1, '{5'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b0}},
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd0, 5'd5, 5'd18, 5'd0, FN_OR), 5'd0, 32'h0, 1'b0, '0},
      '{ACT_LOAD, 32'hffff_ffff, 5'd31, 32'ha5a5_a5a5,
        1'b1, '{5'd31, 32'ha5a5_a5a5, 1'b1, 1'b0, 1'b0}},
      // dependent instructions, offered one after another
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd31, 5'd5, 5'd30, 5'd0, FN_XOR), 5'd0, 32'h0, 1'b0, '0},
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd31, 5'd31, 5'd31, 5'd0, FN_ADDU), 5'd0, 32'h0, 1'b0, '0},
      '{ACT_EXEC, rtype(OPC_RTYPE, 5'd31, 5'd30, 5'd1, 5'd0, FN_AND), 5'd0, 32'h0, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    foreach (dir_rows[i])
      issue_cmd(dir_rows[i].act, dir_rows[i].word, dir_rows[i].li, dir_rows[i].lv,
                dir_rows[i].typed, dir_rows[i].exp);

    // long receiver hold-off while commands keep coming, then a full drain
    snd_idle = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++)
      issue_cmd(ACT_EXEC, rtype(OPC_RTYPE, pick_reg(), pick_reg(), pick_reg(),
                5'($urandom_range(0, 31)), pick_fn()), 5'($urandom), $urandom, 1'b0, '0);
    drain_results();

    // random part
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        if (n >= RAND_ITEMS - CALM_ITEMS) begin
          snd_idle = 1'b0;
          rcv_idle = 1'b0;
        end else begin
          snd_idle = $urandom_range(0, 1);
          rcv_idle = $urandom_range(0, 1);
        end
        if (n == 700 && !hold_req) hold_req = 1'b1;
        if (n == 1200) drain_results();
      end
      k    = $urandom_range(0, 99);
      act  = ACT_EXEC;
      word = $urandom;
      li   = 5'($urandom);
      lv   = $urandom;
      if (k < 22) begin
        act = ACT_LOAD;
        li  = ($urandom_range(0, 1) == 0) ? pick_reg() : 5'($urandom);
        lv  = pick_value();
      end else if (k < 90) begin
        word = rtype(OPC_RTYPE, pick_reg(), pick_reg(), pick_reg(),
                     5'($urandom_range(0, 31)), pick_fn());
      end else if (k < 95) begin
        word[31:26] = OPC_RTYPE;
      end
      issue_cmd(act, word, li, lv, 1'b0, '0);
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
